/* rtl/core/tfaf_pkg.sv */
// tfaf_pkg: shared constants and types of the tcp flow allowlist filter
// no dependencies; imported by tcp_flow_allowlist_filter
`default_nettype none

package tfaf_pkg;

  // default table geometry
  localparam int SERVICES_PER_FAMILY_DEF = 4;
  localparam int PEERS_PER_SERVICE_DEF   = 16;

  // header codes
  localparam logic [15:0] ETH_V4    = 16'h0800;
  localparam logic [15:0] ETH_V6    = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  // tcp flag pattern of a pure syn (syn set, ack clear)
  localparam logic [1:0] TCP_SYN_ONLY = 2'b10;

  // item modes
  localparam logic [1:0] MODE_CLASSIFY = 2'd0;
  localparam logic [1:0] MODE_SERVICE  = 2'd1;
  localparam logic [1:0] MODE_PEER     = 2'd2;

  // configuration port
  localparam int         PADDR_W    = 5;
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_DROP4  = 3'd1;
  localparam logic [2:0] REG_DROP6  = 3'd2;
  localparam logic [2:0] REG_TCP    = 3'd3;
  localparam logic [2:0] REG_ALLOW  = 3'd4;

  typedef enum logic [3:0] {
    RSN_PASS         = 4'd0,
    RSN_BOTH_OFF     = 4'd1,
    RSN_FAMILY       = 4'd2,
    RSN_SHORT        = 4'd3,
    RSN_NOT_TCP      = 4'd4,
    RSN_NO_SERVICE   = 4'd5,
    RSN_UNKNOWN_PEER = 4'd6,
    RSN_NON_IP       = 4'd7,
    RSN_WRITE        = 4'd8
  } reason_t;

endpackage

`default_nettype wire

/* rtl/core/tfaf_ram.sv */
// tfaf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tfaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcp_flow_allowlist_filter.sv */
// tcp_flow_allowlist_filter: pass/drop classifier for parsed packet headers
// depends on tfaf_pkg and tfaf_ram
`default_nettype none

// Every input transaction yields exactly one result transaction. Mode 0 classifies a
// packet from its parsed header fields; modes 1 and 2 write a service slot or a
// peer entry and answer drop 0, reason 8 (mode 3 changes nothing and answers the
// same). The block works on one transaction at a time and holds in_stall high from
// acceptance until its verdict is parked in the output register; a waiting result
// does not block the next input. Writes and most verdicts pass through the evaluate
// and deliver states before out_valid rises; deliver waits while an earlier result
// is still stalled. A non-syn segment in allowlist mode that hits a service slot
// walks the peer entries of that service through one shared compare unit fed by
// the peer ram, one entry per cycle, over at most min(PEERS_PER_SERVICE, 16)
// entries (16 at the defaults). The ram's read is registered, so each entry is
// compared in the cycle after its read, and the walk stops early on a hit. Service
// slots and peer valid flags live in flip-flops that reset clears at once, so no
// clearing pass is needed after reset. Only slot numbers below
// min(SERVICES_PER_FAMILY, 4) and peer numbers below min(PEERS_PER_SERVICE, 16) can
// be addressed by table_index; writes beyond them are acknowledged and ignored.
// Configuration registers are one bit each at byte addresses 0, 4, 8, 12, 16 and
// should only be written while the block is idle.

module tcp_flow_allowlist_filter
  import tfaf_pkg::*;
#(
  parameter int SERVICES_PER_FAMILY = SERVICES_PER_FAMILY_DEF,
  parameter int PEERS_PER_SERVICE   = PEERS_PER_SERVICE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [15:0]        ethertype,
  input  wire logic [7:0]         ip_protocol,
  input  wire logic               ip_header_fits,
  input  wire logic               tcp_header_fits,
  input  wire logic [1:0]         tcp_flags,
  input  wire logic [15:0]        destination_port,
  input  wire logic [15:0]        source_port,
  input  wire logic [63:0]        address_high,
  input  wire logic [63:0]        address_low,
  input  wire logic [6:0]         table_index,
  input  wire logic               entry_valid,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    drop,
  output logic      [3:0]         reason
);

  // reachable table geometry (table_index carries 2 slot bits and 4 peer bits)
  localparam int SLOT_USE   = (SERVICES_PER_FAMILY < 4) ? SERVICES_PER_FAMILY : 4;
  localparam int PEER_USE   = (PEERS_PER_SERVICE < 16) ? PEERS_PER_SERVICE : 16;
  localparam int SLOT_COUNT = 2 * SLOT_USE;
  localparam int PEER_DEPTH = SLOT_COUNT * PEER_USE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int PA_W       = $clog2(PEER_DEPTH);
  localparam int CNT_W      = $clog2(PEER_USE + 1);
  // peer ram word: {address high, address low, port}
  localparam int PEER_W     = 64 + 64 + 16;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_DONE} state_t;

  state_t state;

  // configuration registers
  logic filter_enabled;
  logic drop_v4;
  logic drop_v6;
  logic drop_non_tcp_mode;
  logic allowlist_mode;
  logic cfg_write;

  // captured transaction
  logic [1:0]  itm_mode;
  logic [15:0] itm_ethertype;
  logic [7:0]  itm_proto;
  logic        itm_ip_fits;
  logic        itm_tcp_fits;
  logic [1:0]  itm_flags;
  logic [15:0] itm_dport;
  logic [15:0] itm_sport;
  logic [63:0] itm_addr_hi;
  logic [63:0] itm_addr_lo;
  logic [6:0]  itm_index;
  logic        itm_entry_valid;

  // tables
  logic        svc_valid [SLOT_COUNT];
  logic [15:0] svc_port  [SLOT_COUNT];
  logic        peer_valid [PEER_DEPTH];

  // evaluation
  logic        in_accept;
  logic        is4;
  logic        is6;
  reason_t     front;
  logic        svc_hit;
  logic [SLOT_W-1:0] svc_idx;
  reason_t     eval_reason;
  logic        eval_scan;
  logic        slot_ok;
  logic        peer_ok;
  logic [SLOT_W-1:0] svc_widx;
  logic [PA_W-1:0]   peer_widx;

  // peer walk
  logic [CNT_W-1:0]  cnt;
  logic [PA_W-1:0]   base;
  logic              cmp_pend;
  logic              cmp_vld;
  logic              scan_hit;
  logic              scan_end;
  reason_t           res;

  // peer ram
  logic              ram_we;
  logic              ram_re;
  logic [PA_W-1:0]   ram_raddr;
  logic [PEER_W-1:0] ram_wdata;
  logic [PEER_W-1:0] ram_rdata;

  // ---------------------------------------------------------------------------
  // configuration port: zero wait states, one bit per register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enabled    <= 1'b0;
      drop_v4           <= 1'b0;
      drop_v6           <= 1'b0;
      drop_non_tcp_mode <= 1'b0;
      allowlist_mode    <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_ENABLE: filter_enabled    <= pwdata[0];
        REG_DROP4:  drop_v4           <= pwdata[0];
        REG_DROP6:  drop_v6           <= pwdata[0];
        REG_TCP:    drop_non_tcp_mode <= pwdata[0];
        REG_ALLOW:  allowlist_mode    <= pwdata[0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_ENABLE: prdata[0] = filter_enabled;
      REG_DROP4:  prdata[0] = drop_v4;
      REG_DROP6:  prdata[0] = drop_v6;
      REG_TCP:    prdata[0] = drop_non_tcp_mode;
      REG_ALLOW:  prdata[0] = allowlist_mode;
      default:    prdata    = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input capture
  // ---------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      itm_mode        <= mode;
      itm_ethertype   <= ethertype;
      itm_proto       <= ip_protocol;
      itm_ip_fits     <= ip_header_fits;
      itm_tcp_fits    <= tcp_header_fits;
      itm_flags       <= tcp_flags;
      itm_dport       <= destination_port;
      itm_sport       <= source_port;
      itm_addr_hi     <= address_high;
      itm_addr_lo     <= address_low;
      itm_index       <= table_index;
      itm_entry_valid <= entry_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // evaluate: policy chain and service match, in the S_EVAL cycle
  // ---------------------------------------------------------------------------
  assign is4 = (itm_ethertype == ETH_V4);
  assign is6 = (itm_ethertype == ETH_V6);

  always_comb begin
    // common front of the tcp modes
    priority if (is6 ? drop_v6 : drop_v4) begin
      front = RSN_FAMILY;
    end else if (!itm_ip_fits) begin
      front = RSN_SHORT;
    end else if (itm_proto != PROTO_TCP) begin
      front = RSN_NOT_TCP;
    end else if (!itm_tcp_fits) begin
      front = RSN_SHORT;
    end else begin
      front = RSN_PASS;
    end

    // lowest numbered valid slot of the family wins
    svc_hit = 1'b0;
    svc_idx = '0;
    for (int s = SLOT_USE - 1; s >= 0; s--) begin
      if (svc_valid[SLOT_W'(is6 ? SLOT_USE + s : s)] &&
          svc_port[SLOT_W'(is6 ? SLOT_USE + s : s)] == itm_dport) begin
        svc_hit = 1'b1;
        svc_idx = SLOT_W'(is6 ? SLOT_USE + s : s);
      end
    end

    eval_scan = 1'b0;
    priority if (!filter_enabled) begin
      eval_reason = RSN_PASS;
    end else if (drop_v4 && drop_v6) begin
      eval_reason = RSN_BOTH_OFF;
    end else if (allowlist_mode) begin
      priority if (!is4 && !is6) begin
        eval_reason = RSN_PASS;           // non-ip passes in allowlist mode
      end else if (front != RSN_PASS) begin
        eval_reason = front;
      end else if (!svc_hit) begin
        eval_reason = RSN_NO_SERVICE;
      end else if (itm_flags == TCP_SYN_ONLY) begin
        eval_reason = RSN_PASS;           // pure syn skips the peer check
      end else begin
        eval_reason = RSN_UNKNOWN_PEER;
        eval_scan   = 1'b1;
      end
    end else if (drop_non_tcp_mode) begin
      eval_reason = (!is4 && !is6) ? RSN_NON_IP : front;
    end else if ((drop_v4 && is4) || (drop_v6 && is6)) begin
      eval_reason = RSN_FAMILY;
    end else begin
      eval_reason = RSN_PASS;
    end
  end

  // write targets; slot and peer numbers past the tables are ignored
  assign slot_ok   = int'(itm_index[5:4]) < SLOT_USE;
  assign peer_ok   = int'(itm_index[3:0]) < PEER_USE;
  assign svc_widx  = SLOT_W'(int'(itm_index[6]) * SLOT_USE + int'(itm_index[5:4]));
  assign peer_widx = PA_W'((int'(itm_index[6]) * SLOT_USE + int'(itm_index[5:4])) * PEER_USE
                           + int'(itm_index[3:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        svc_valid[i] <= 1'b0;
      end
      for (int i = 0; i < PEER_DEPTH; i++) begin
        peer_valid[i] <= 1'b0;
      end
    end else if (state == S_EVAL && slot_ok) begin
      if (itm_mode == MODE_SERVICE) begin
        svc_valid[svc_widx] <= itm_entry_valid;
        svc_port[svc_widx]  <= itm_dport;
      end else if (itm_mode == MODE_PEER && peer_ok) begin
        peer_valid[peer_widx] <= itm_entry_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // peer ram and the shared compare unit
  // ---------------------------------------------------------------------------
  assign ram_we    = (state == S_EVAL) && (itm_mode == MODE_PEER) && slot_ok && peer_ok;
  assign ram_wdata = {itm_addr_hi, itm_addr_lo, itm_sport};
  assign ram_raddr = base + PA_W'(cnt);
  assign scan_end  = (cnt == CNT_W'(PEER_USE));
  assign ram_re    = (state == S_SCAN) && !scan_hit && !scan_end;

  tfaf_ram #(
    .WIDTH (PEER_W),
    .DEPTH (PEER_DEPTH)
  ) u_peer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (peer_widx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // v4 compares only the low 32 address bits, v6 all 128
  assign scan_hit = cmp_pend && cmp_vld &&
                    (ram_rdata[15:0] == itm_sport) &&
                    (ram_rdata[47:16] == itm_addr_lo[31:0]) &&
                    (!is6 || ((ram_rdata[79:48] == itm_addr_lo[63:32]) &&
                              (ram_rdata[143:80] == itm_addr_hi)));

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      cmp_pend  <= 1'b0;
    end else begin
      // a verdict loaded in S_DONE takes the place of the one leaving
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (itm_mode == MODE_CLASSIFY && eval_scan) begin
            state    <= S_SCAN;
            cnt      <= '0;
            cmp_pend <= 1'b0;
            base     <= PA_W'(int'(svc_idx) * PEER_USE);
          end else begin
            res   <= (itm_mode == MODE_CLASSIFY) ? eval_reason : RSN_WRITE;
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare it the cycle after
          if (scan_hit) begin
            res   <= RSN_PASS;
            state <= S_DONE;
          end else if (scan_end) begin
            res   <= RSN_UNKNOWN_PEER;
            state <= S_DONE;
          end else begin
            cnt      <= cnt + 1'b1;
            cmp_pend <= 1'b1;
            cmp_vld  <= peer_valid[ram_raddr];
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            reason    <= res;
            drop      <= (res != RSN_PASS) && (res != RSN_WRITE);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_drop_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drop == ((reason != RSN_PASS) && (reason != RSN_WRITE))))
    else $error("drop flag disagrees with reason code");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= CNT_W'(PEER_USE)))
    else $error("peer walk ran past the service's entries");

  a_scan_classify: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (itm_mode == MODE_CLASSIFY))
    else $error("peer walk started for a table write");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_EVAL))
    else $error("accepted transaction not evaluated");

  a_deliver: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !(out_valid && out_stall)) |=> (out_valid && (state == S_IDLE)))
    else $error("finished verdict not delivered");

endmodule

`default_nettype wire
